[design/sobel_gradient_magnitude_assert.svh]
// assertion helpers used by the checker file
`ifndef SOBEL_GRADIENT_MAGNITUDE_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_ASSERT_SVH

// checked on every rising edge outside reset
`define SGM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising edge, reset included
`define SGM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/sgm_pkg.sv]
package sgm_pkg;

   localparam int PIX_W         = 8;
   localparam int CFG_W         = 12;
   localparam int GRAD_W        = 11;
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // per-item flags handed from the scan counters down the pipe
   typedef struct packed {
      logic emit;
      logic frame_end;
   } item_ctrl_type;

endpackage

[design/sgm_scan_ctrl.sv]
module sgm_scan_ctrl #(
   parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  sgm_pkg::csr_index_type        csr_addr,
   input  logic [sgm_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          advance,
   output logic [$clog2(MAX_WIDTH)-1:0]  col_addr,
   output sgm_pkg::item_ctrl_type        ctrl
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int XW0 = $clog2(MAX_WIDTH + 1);
   localparam int YW0 = $clog2(MAX_HEIGHT + 1);
   localparam int XW  = (sgm_pkg::CFG_W > XW0) ? sgm_pkg::CFG_W : XW0;
   localparam int YW  = (sgm_pkg::CFG_W > YW0) ? sgm_pkg::CFG_W : YW0;

   logic [sgm_pkg::CFG_W-1:0] width_ff;
   logic [sgm_pkg::CFG_W-1:0] height_ff;
   logic [AW-1:0]             col_ff, col_in;
   logic [RW-1:0]             row_ff, row_in;

   logic [XW-1:0] width_x, width_eff, last_col_idx;
   logic [YW-1:0] height_x, height_eff, last_row_idx;
   logic          last_col, last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sgm_pkg::WIDTH_RESET;
         height_ff <= sgm_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            sgm_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            sgm_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
         endcase
      end
   end

   // clamp the programmed size to 3 .. maximum
   always_comb begin
      width_x  = XW'(width_ff);
      height_x = YW'(height_ff);
      priority if (width_x < XW'(3))         width_eff = XW'(3);
      else if (width_x > XW'(MAX_WIDTH))     width_eff = XW'(MAX_WIDTH);
      else                                   width_eff = width_x;
      priority if (height_x < YW'(3))        height_eff = YW'(3);
      else if (height_x > YW'(MAX_HEIGHT))   height_eff = YW'(MAX_HEIGHT);
      else                                   height_eff = height_x;
      last_col_idx = width_eff - XW'(1);
      last_row_idx = height_eff - YW'(1);
   end

   assign last_col = XW'(col_ff) >= last_col_idx;
   assign last_row = YW'(row_ff) >= last_row_idx;

   assign ctrl.emit      = (col_ff >= AW'(2)) && (row_ff >= RW'(2));
   assign ctrl.frame_end = ctrl.emit && last_col && last_row;
   assign col_addr       = col_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[design/sgm_line_store.sv]
module sgm_line_store #(
   parameter int DEPTH = sgm_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [2*sgm_pkg::PIX_W-1:0]    rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [2*sgm_pkg::PIX_W-1:0]    wr_data
);

   // one entry per column: upper byte the older line, lower byte the newer
   logic [2*sgm_pkg::PIX_W-1:0] mem [DEPTH];
   logic [2*sgm_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sgm_window_calc.sv]
module sgm_window_calc (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift_en,
   input  sgm_pkg::pixel_type                 top,
   input  sgm_pkg::pixel_type                 mid,
   input  sgm_pkg::pixel_type                 pixel,
   input  sgm_pkg::item_ctrl_type             ctrl,
   output logic                               ready,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sgm_pkg::PIX_W-1:0]          rsp_tdata,   // magnitude
   output logic                               rsp_tlast    // frame_end
);

   localparam int GW = sgm_pkg::GRAD_W;
   localparam int SW = sgm_pkg::PIX_W + 2;

   sgm_pkg::pixel_type win_ff [3][3];
   sgm_pkg::pixel_type win_in [3][3];

   logic                 v2_ff, v2_in;
   logic                 last2_ff;
   logic signed [GW-1:0] gx_ff, gy_ff, gx_in, gy_in;
   logic                 out_rdy;

   logic [SW-1:0]        pos_y, neg_y, pos_x, neg_x;
   logic [GW-2:0]        abs_x, abs_y;
   logic [GW-1:0]        mag_sum;
   logic                 rsp_valid_ff;
   logic [sgm_pkg::PIX_W-1:0] rsp_data_ff;
   logic                 rsp_last_ff;

   function automatic logic [SW-1:0] wsum(input sgm_pkg::pixel_type a,
                                          input sgm_pkg::pixel_type b,
                                          input sgm_pkg::pixel_type c);
      return SW'(a) + {1'b0, b, 1'b0} + SW'(c);
   endfunction

   // row 0 oldest line, column 2 newest sample
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = top;
      win_in[1][2] = mid;
      win_in[2][2] = pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      pos_y = wsum(win_in[2][0], win_in[2][1], win_in[2][2]);
      neg_y = wsum(win_in[0][0], win_in[0][1], win_in[0][2]);
      pos_x = wsum(win_in[0][2], win_in[1][2], win_in[2][2]);
      neg_x = wsum(win_in[0][0], win_in[1][0], win_in[2][0]);
      gy_in = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
      gx_in = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
   end

   assign out_rdy = !rsp_valid_ff || rsp_tready;
   assign ready   = !v2_ff || out_rdy;
   assign v2_in   = shift_en && ctrl.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready) begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         gx_ff    <= gx_in;
         gy_ff    <= gy_in;
         last2_ff <= ctrl.frame_end;
      end
   end

   always_comb begin
      abs_x   = gx_ff[GW-1] ? (GW-1)'(-gx_ff) : gx_ff[GW-2:0];
      abs_y   = gy_ff[GW-1] ? (GW-1)'(-gy_ff) : gy_ff[GW-2:0];
      mag_sum = GW'(abs_x) + GW'(abs_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_data_ff <= (mag_sum > GW'(255)) ? '1 : mag_sum[sgm_pkg::PIX_W-1:0];
         rsp_last_ff <= last2_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[design/sobel_gradient_magnitude.sv]
// pipe: input register with the line store read, gradient registers, result register
// throughput: one pixel per clock unless a stalled result holds it back, set by the
// single-port-pair line store read and write per column; a stalled result lets up to
// two further items in before req_tready drops
// reset: synchronous, clears counters, window, pipe valids and sets 640 x 480
// the line store is not cleared; stale entries reach only rows 0 and 1, which give no result
module sobel_gradient_magnitude #(
   parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sgm_pkg::PIX_W-1:0]     req_tdata,   // pixel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sgm_pkg::PIX_W-1:0]     rsp_tdata,   // magnitude
   output logic                          rsp_tlast,   // frame_end
   input  logic                          csr_we,
   input  sgm_pkg::csr_index_type        csr_addr,
   input  logic [sgm_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                   accept;
   logic                   rdy1, rdy2, leave1;
   logic [AW-1:0]          col_addr;
   sgm_pkg::item_ctrl_type ctrl0;

   logic                   v1_ff;
   sgm_pkg::pixel_type     px1_ff;
   sgm_pkg::item_ctrl_type ctrl1_ff;
   logic [AW-1:0]          addr1_ff;

   logic [2*sgm_pkg::PIX_W-1:0] ls_rd, ls_wr;
   sgm_pkg::pixel_type          top, mid;

   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign accept     = req_tvalid && rdy1;
   assign leave1     = v1_ff && rdy2;

   sgm_scan_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .col_addr  (col_addr),
      .ctrl      (ctrl0)
   );

   // the same column comes back only a full line later (width >= 3), so the
   // write-back always lands before the next read of that entry
   sgm_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .rd_en   (rdy1),
      .rd_addr (col_addr),
      .rd_data (ls_rd),
      .wr_en   (leave1),
      .wr_addr (addr1_ff),
      .wr_data (ls_wr)
   );

   assign top   = ls_rd[2*sgm_pkg::PIX_W-1:sgm_pkg::PIX_W];
   assign mid   = ls_rd[sgm_pkg::PIX_W-1:0];
   assign ls_wr = {mid, px1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         px1_ff   <= req_tdata;
         ctrl1_ff <= ctrl0;
         addr1_ff <= col_addr;
      end
   end

   sgm_window_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (leave1),
      .top        (top),
      .mid        (mid),
      .pixel      (px1_ff),
      .ctrl       (ctrl1_ff),
      .ready      (rdy2),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[design/sgm_checker.sv]
`include "sobel_gradient_magnitude_assert.svh"

module sgm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [sgm_pkg::PIX_W-1:0] rsp_tdata,
   input logic                      rsp_tlast
);

   // a held result keeps its payload
   `SGM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // input only backs up behind a stalled result
   `SGM_ASSERT(a_req_stall_cause, !req_tready |-> rsp_tvalid && !rsp_tready, "input stalled with output free")

   // no result straight out of reset
   `SGM_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "result valid after reset")

   // a free output never blocks the input
   `SGM_ASSERT(a_req_free, rsp_tready && req_tvalid |-> req_tready, "input blocked with output ready")

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (.*);

[sim/sobel_gradient_magnitude_tb.sv]
`timescale 1ns / 1ps

module sobel_gradient_magnitude_tb;

   localparam int MAX_W         = sgm_pkg::MAX_WIDTH_DEF;
   localparam int MAX_H         = sgm_pkg::MAX_HEIGHT_DEF;
   localparam int PW            = sgm_pkg::PIX_W;
   localparam int CW            = sgm_pkg::CFG_W;
   localparam int RANDOM_ITEMS  = 500;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct packed {
      sgm_pkg::pixel_type magnitude;
      logic               frame_end;
   } gradient_type;

   typedef struct packed {
      sgm_pkg::pixel_type px;
      logic               typed;
      gradient_type       res;
   } dir_row_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef enum logic [1:0] {
      PIX_UNIFORM,
      PIX_BINARY,
      PIX_SMOOTH
   } pixel_style_type;

   localparam gradient_type NO_RES = '0;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PW-1:0]          req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PW-1:0]          rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   sgm_pkg::csr_index_type csr_addr   = sgm_pkg::CSR_FRAME_WIDTH;
   logic [CW-1:0]          csr_wdata  = '0;

   idle_mode_type idle_mode    = IDLE_NONE;
   int unsigned   phase_count  = 0;
   int unsigned   pixels_sent  = 0;
   int unsigned   error_count  = 0;
   int unsigned   cycle_count  = 0;

   gradient_type expected_gradients [$];

   // predictor state
   logic [CW-1:0]      cfg_width  = sgm_pkg::WIDTH_RESET;
   logic [CW-1:0]      cfg_height = sgm_pkg::HEIGHT_RESET;
   sgm_pkg::pixel_type line_a [MAX_W] = '{default: '0};
   sgm_pkg::pixel_type line_b [MAX_W] = '{default: '0};
   sgm_pkg::pixel_type win [9]        = '{default: '0};
   int unsigned        col_cnt = 0;
   int unsigned        row_cnt = 0;

   // three 3x3 frames, result on the ninth pixel of each
   dir_row_type directed_rows [27] = '{
      '{8'd255, 1'b0, NO_RES}, '{8'd255, 1'b0, NO_RES}, '{8'd255, 1'b0, NO_RES},
      '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES},
      '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b1, '{8'd255, 1'b1}},
      '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES},
      '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES},
      '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b1, '{8'd0, 1'b1}},
      '{8'd10,  1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES},
      '{8'd10,  1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES},
      '{8'd10,  1'b0, NO_RES}, '{8'd0,   1'b0, NO_RES}, '{8'd0,   1'b1, '{8'd40, 1'b1}}
   };

   sobel_gradient_magnitude u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [CW-1:0] v, input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic bit sobel_predict(input sgm_pkg::pixel_type px,
                                        output gradient_type res);
      int unsigned        w, h, c, r, idx;
      sgm_pkg::pixel_type top, mid;
      bit                 last_col, last_row;
      int                 gx, gy, m;
      int                 k;
      w        = clamp_dim(cfg_width, MAX_W);
      h        = clamp_dim(cfg_height, MAX_H);
      c        = col_cnt;
      r        = row_cnt;
      idx      = (c < MAX_W) ? c : MAX_W - 1;
      top      = line_b[idx];
      mid      = line_a[idx];
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      for (k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      line_b[idx] = mid;
      line_a[idx] = px;
      res = NO_RES;
      sobel_predict = 1'b0;
      if (r >= 2 && c >= 2) begin
         gy = int'(win[6]) + 2 * int'(win[7]) + int'(win[8])
            - int'(win[0]) - 2 * int'(win[1]) - int'(win[2]);
         gx = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
            - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
         m = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         res.magnitude = (m > 255) ? 8'd255 : sgm_pkg::pixel_type'(m);
         res.frame_end = last_col && last_row;
         sobel_predict = 1'b1;
      end
      if (last_col) begin
         col_cnt = 0;
         row_cnt = last_row ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 73;
         IDLE_BOTH:   return $urandom_range(99) < 11;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 73;
         IDLE_BOTH:     return $urandom_range(99) < 11;
         default:       return 1'b0;
      endcase
   endfunction

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_pixel(input sgm_pkg::pixel_type px, input bit use_typed,
                             input gradient_type typed_res);
      bit           taken;
      bit           produced;
      gradient_type res;
      while (sender_idles()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      pixels_sent++;
      produced = sobel_predict(px, res);
      if (use_typed) res = typed_res;
      if (produced || use_typed) expected_gradients.push_back(res);
   endtask

   task automatic send_frame(input pixel_style_type style);
      int unsigned        w, h, n;
      int                 level;
      sgm_pkg::pixel_type px;
      w     = clamp_dim(cfg_width, MAX_W);
      h     = clamp_dim(cfg_height, MAX_H);
      level = $urandom_range(255);
      for (n = 0; n < w * h; n++) begin
         case (style)
            PIX_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
            PIX_SMOOTH: begin
               // slow ramps: each pixel differs from the one before by at most 4
               level = level + int'($urandom_range(8)) - 4;
               if (level < 0) level = 0;
               if (level > 255) level = 255;
               px = sgm_pkg::pixel_type'(level);
            end
            default: px = sgm_pkg::pixel_type'($urandom);
         endcase
         send_pixel(px, 1'b0, NO_RES);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_gradients.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic start_phase();
      drain();
      idle_mode <= idle_mode_type'(phase_count % 4);
      phase_count++;
   endtask

   task automatic write_csr(input sgm_pkg::csr_index_type idx, input logic [CW-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sgm_pkg::CSR_FRAME_WIDTH) cfg_width = val;
      else cfg_height = val;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= !receiver_stalls();
   end

   always @(negedge clock) begin : check_results
      gradient_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_gradients.size() == 0) begin
            $error("result with nothing expected: magnitude %0d frame_end %0d",
                   rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_gradients.pop_front();
            if (rsp_tdata !== want.magnitude) begin
               $error("magnitude: expected %0d, actual %0d", want.magnitude, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $error("frame_end: expected %0d, actual %0d", want.frame_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned start_count;
      int unsigned pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // height left at its reset value
      start_phase();
      write_csr(sgm_pkg::CSR_FRAME_WIDTH, 12'd3);
      send_frame(PIX_UNIFORM);

      start_phase();
      write_csr(sgm_pkg::CSR_FRAME_HEIGHT, 12'd3);
      foreach (directed_rows[i])
         send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].res);

      // sizes below the minimum are clamped up
      start_phase();
      write_csr(sgm_pkg::CSR_FRAME_WIDTH, 12'd1);
      write_csr(sgm_pkg::CSR_FRAME_HEIGHT, 12'd2);
      send_frame(PIX_SMOOTH);
      start_phase();
      write_csr(sgm_pkg::CSR_FRAME_WIDTH, 12'd0);
      write_csr(sgm_pkg::CSR_FRAME_HEIGHT, 12'd0);
      send_frame(PIX_BINARY);

      start_count = pixels_sent;
      while (pixels_sent - start_count < RANDOM_ITEMS) begin
         start_phase();
         pick = $urandom_range(9);
         if (pick == 0) write_csr(sgm_pkg::CSR_FRAME_WIDTH, CW'($urandom_range(2)));
         else write_csr(sgm_pkg::CSR_FRAME_WIDTH, CW'($urandom_range(24, 3)));
         if (pick == 1) write_csr(sgm_pkg::CSR_FRAME_HEIGHT, CW'($urandom_range(2)));
         else if (pick != 2)
            write_csr(sgm_pkg::CSR_FRAME_HEIGHT, CW'($urandom_range(12, 3)));
         repeat ($urandom_range(3, 1)) send_frame(pixel_style_type'($urandom_range(2)));
      end

      drain();
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
